// ===== rtl/sts_pkg.sv =====
// Package with the item types, codes and constants of the search transposition table.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int MAX_PLY_DEF    = 128;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS_USED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATE_VALUE      = 2'd1;

    localparam logic [4:0]  INDEX_BITS_USED_RST = 5'd16;
    localparam logic [14:0] MATE_VALUE_RST      = 15'd32000;

    localparam logic signed [15:0] SCORE_LIM = 16'sd32767;

    typedef enum logic [1:0] {
        ACT_PROBE = 2'd0,
        ACT_STORE = 2'd1,
        ACT_CLEAR = 2'd2
    } sts_action_t;

    typedef enum logic [1:0] {
        BOUND_EXACT = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_UPPER = 2'd2
    } sts_bound_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MATCH,
        S_RESOLVE
    } sts_state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [63:0]        key;
        logic [15:0]        move_code;
        logic signed [15:0] score_in;
        logic [7:0]         depth_in;
        logic signed [15:0] alpha_in;
        logic signed [15:0] beta_in;
        logic [7:0]         ply;
    } sts_req_t;

    typedef struct packed {
        logic               hit;
        logic               cutoff;
        logic [15:0]        move_out;
        logic signed [15:0] score_out;
        logic signed [15:0] alpha_out;
        logic signed [15:0] beta_out;
        logic [1:0]         bound_kind;
    } sts_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [7:0]         depth;
        logic [1:0]         bound;
    } sts_entry_t;

endpackage

`default_nettype wire

// ===== rtl/sts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module sts_ram #(
    parameter int WIDTH     = 8,
    parameter int ADDR_BITS = 4
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/search_transposition_table.sv =====
// Direct-mapped transposition table: top level with control, slot memory and result register.
//
// Requests enter on req with req_valid/req_stall; an item is taken when req_valid is
// high and req_stall low. Each item gives exactly one result on rsp with rsp_valid and
// rsp_stall. Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high.
// The slot read of the single table memory is issued in the accepting cycle. The next
// cycle does key match and mate-distance adjustment, and a store writes its slot there.
// The cycle after that resolves the window and loads the result register once it is
// free. One item is in flight at a time and req_stall stays high until its result loads,
// so no new item is taken before the result of the last one has loaded.
// A clear item walks the whole memory, one slot per cycle, and then loads its result
// through the resolve step.
// After reset the same walk over all slots runs before the first item is taken;
// configuration writes are taken during it.
// A result held by rsp_stall stays in the result register; the next item is still taken
// and waits in its resolve step until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module search_transposition_table #(
    parameter int INDEX_BITS = sts_pkg::INDEX_BITS_DEF,
    parameter int MAX_PLY    = sts_pkg::MAX_PLY_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire sts_pkg::sts_req_t                   req,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output sts_pkg::sts_rsp_t                        rsp,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [sts_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import sts_pkg::*;

    localparam int ENTRY_W = $bits(sts_entry_t);

    function automatic logic [INDEX_BITS-1:0] index_mask(input logic [4:0] n);
        logic [INDEX_BITS-1:0] m;
        for (int i = 0; i < INDEX_BITS; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    function automatic logic signed [16:0] mate_thresh(input logic [14:0] mv);
        return $signed({2'b00, mv}) - 17'(MAX_PLY);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767)
        begin
            r = SCORE_LIM;
        end
        else if (v < -18'sd32767)
        begin
            r = -SCORE_LIM;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] mate_adjust(
        input logic signed [15:0] s,
        input logic [7:0]         p,
        input logic               storing,
        input logic signed [16:0] t
    );
        logic signed [17:0] sx;
        logic signed [17:0] px;
        logic signed [17:0] tx;
        logic signed [15:0] r;
        sx = {{2{s[15]}}, s};
        px = {10'b0, p};
        tx = {t[16], t};
        if (sx >= tx)
        begin
            r = sat16(storing ? sx + px : sx - px);
        end
        else if (sx <= -tx)
        begin
            r = sat16(storing ? sx - px : sx + px);
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    sts_state_t               state_reg, state_next;
    logic [INDEX_BITS-1:0]    idx_mask_reg, idx_mask_next;
    logic signed [16:0]       thresh_reg, thresh_next;
    logic [INDEX_BITS-1:0]    clr_addr_reg, clr_addr_next;
    logic                     pend_reg, pend_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    sts_rsp_t                 rsp_reg, rsp_next;
    sts_req_t                 item_reg;
    logic [INDEX_BITS-1:0]    idx_reg;
    logic                     hit_reg;
    logic                     depth_ok_reg;
    logic [15:0]              move_reg;
    logic [1:0]               bound_reg;
    logic signed [15:0]       score_reg;

    logic                     accept;
    logic                     rsp_load;
    logic                     ram_we;
    logic [INDEX_BITS-1:0]    ram_waddr;
    sts_entry_t               ram_wdata;
    logic [INDEX_BITS-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    sts_entry_t               rd_entry;

    logic signed [15:0]       st_score;
    logic signed [15:0]       st_adj;
    logic [1:0]               st_bound;
    logic signed [15:0]       pr_adj;
    logic                     match;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_entry  = sts_entry_t'(ram_rdata);
    assign ram_raddr = req.key[INDEX_BITS-1:0] & idx_mask_reg;

    sts_ram #(
        .WIDTH     (ENTRY_W),
        .ADDR_BITS (INDEX_BITS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ENTRY_W'(ram_wdata)),
        .re    (accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        st_score = (item_reg.score_in == -16'sd32768) ? -SCORE_LIM : item_reg.score_in;
        st_adj   = mate_adjust(st_score, item_reg.ply, 1'b1, thresh_reg);
        if (item_reg.score_in <= item_reg.alpha_in)
        begin
            st_bound = BOUND_UPPER;
        end
        else if (item_reg.score_in >= item_reg.beta_in)
        begin
            st_bound = BOUND_LOWER;
        end
        else
        begin
            st_bound = BOUND_EXACT;
        end
        pr_adj = mate_adjust(rd_entry.score, item_reg.ply, 1'b0, thresh_reg);
        match  = rd_entry.valid && (rd_entry.key == item_reg.key);
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pend_next     = pend_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    state_next = pend_reg ? S_RESOLVE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = 1'b1;
                    if (req.action == ACT_CLEAR)
                    begin
                        state_next    = S_CLEAR;
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        state_next = S_MATCH;
                    end
                end
            end
            S_MATCH:
            begin
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                    pend_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        rsp_load  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            S_MATCH:
            begin
                if (item_reg.action == ACT_STORE)
                begin
                    ram_we          = 1'b1;
                    ram_wdata.valid = 1'b1;
                    ram_wdata.key   = item_reg.key;
                    ram_wdata.move  = item_reg.move_code;
                    ram_wdata.score = st_adj;
                    ram_wdata.depth = item_reg.depth_in;
                    ram_wdata.bound = st_bound;
                end
            end
            S_RESOLVE:
            begin
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.alpha_out  = item_reg.alpha_in;
        rsp_next.beta_out   = item_reg.beta_in;
        if (item_reg.action == ACT_STORE)
        begin
            rsp_next.score_out  = score_reg;
            rsp_next.bound_kind = bound_reg;
        end
        else if (item_reg.action == ACT_PROBE && hit_reg)
        begin
            rsp_next.hit        = 1'b1;
            rsp_next.move_out   = move_reg;
            rsp_next.score_out  = score_reg;
            rsp_next.bound_kind = bound_reg;
            if (depth_ok_reg)
            begin
                unique case (bound_reg)
                    BOUND_EXACT:
                    begin
                        rsp_next.cutoff = 1'b1;
                    end
                    BOUND_LOWER:
                    begin
                        if (score_reg > item_reg.alpha_in)
                        begin
                            rsp_next.alpha_out = score_reg;
                        end
                        rsp_next.cutoff = (rsp_next.alpha_out >= rsp_next.beta_out);
                    end
                    default:
                    begin
                        if (score_reg < item_reg.beta_in)
                        begin
                            rsp_next.beta_out = score_reg;
                        end
                        rsp_next.cutoff = (rsp_next.alpha_out >= rsp_next.beta_out);
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        idx_mask_next = idx_mask_reg;
        thresh_next   = thresh_reg;
        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == CFG_INDEX_BITS_USED)
            begin
                idx_mask_next = index_mask(cfg_data[4:0]);
            end
            else if (cfg_index == CFG_MATE_VALUE)
            begin
                thresh_next = mate_thresh(cfg_data[14:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            idx_mask_reg  <= index_mask(INDEX_BITS_USED_RST);
            thresh_reg    <= mate_thresh(MATE_VALUE_RST);
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            idx_mask_reg  <= idx_mask_next;
            thresh_reg    <= thresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
            idx_reg  <= ram_raddr;
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg      <= match;
            depth_ok_reg <= (rd_entry.depth >= item_reg.depth_in);
            move_reg     <= rd_entry.move;
            if (item_reg.action == ACT_STORE)
            begin
                score_reg <= st_adj;
                bound_reg <= st_bound;
            end
            else
            begin
                score_reg <= pr_adj;
                bound_reg <= rd_entry.bound;
            end
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sts_checker.sv =====
// Port-level checker for the search transposition table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sts_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              req_valid,
    input wire logic              req_stall,
    input wire logic              rsp_valid,
    input wire logic              rsp_stall,
    input wire sts_pkg::sts_rsp_t rsp
);

    import sts_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("A stalled result item changed or was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("A second item was taken while one is still in flight.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.hit |-> rsp.move_out == 16'd0 && !rsp.cutoff)
    else $error("A result without a hit carries a move or a cutoff.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.cutoff && rsp.bound_kind != BOUND_EXACT
            |-> rsp.alpha_out >= rsp.beta_out)
    else $error("A bound cutoff was reported with an open window.");

endmodule

bind search_transposition_table sts_checker u_sts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

// ===== tb/tb_search_transposition_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the search transposition table: random and directed items against a table predictor.
module tb_search_transposition_table;
    import sts_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int PLY_LIMIT = 128;
    localparam int TABLE_BITS = 16;
    localparam int IDLE_LIMIT = 250000;
    localparam int PHASE_COUNT = 7;
    localparam int PHASE_ITEMS = 280;
    localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_0001;
    localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_0002;
    localparam logic [63:0] KEY_C = 64'h5A5A_A5A5_0F0F_0003;
    localparam logic [63:0] KEY_D = 64'hA5A5_5A5A_F0F0_0004;
    localparam logic [63:0] KEY_E = 64'h8000_0000_0000_0005;
    localparam logic [63:0] KEY_F = 64'h7FFF_FFFF_FFFF_0006;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    sts_req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    sts_rsp_t rsp;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    sts_req_t pending_reqs[$];
    sts_rsp_t expected_rsps[$];
    sts_entry_t tt_slots[int unsigned];
    logic [4:0] model_index_bits = INDEX_BITS_USED_RST;
    logic [14:0] model_mate_value = MATE_VALUE_RST;
    logic [63:0] key_pool[16];

    bit req_taken = 1'b0;
    int send_gap = 0;
    int burst_left = 0;
    int stall_tick = 0;
    int stall_mode = 0;
    int idle_cycles = 0;
    int mismatch_count = 0;
    int probe_count = 0;
    int store_count = 0;
    int clear_count = 0;
    int hit_count = 0;
    int cutoff_count = 0;

    search_transposition_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_score(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32767)
        begin
            return -32767;
        end
        return v;
    endfunction

    function automatic int mate_shift(int s, int ply_dist, int dir);
        int thresh;
        thresh = int'(model_mate_value) - PLY_LIMIT;
        if (s >= thresh)
        begin
            return clamp_score(s + dir * ply_dist);
        end
        if (s <= -thresh)
        begin
            return clamp_score(s - dir * ply_dist);
        end
        return s;
    endfunction

    function automatic sts_rsp_t predict_tt_result(sts_req_t r);
        sts_rsp_t res;
        sts_entry_t ent;
        int unsigned slot;
        int n;
        int s;
        int a;
        int b;
        int sv;
        logic [63:0] mask;
        logic [1:0] bnd;
        res = '0;
        a = $signed(r.alpha_in);
        b = $signed(r.beta_in);
        n = (model_index_bits > TABLE_BITS) ? TABLE_BITS : int'(model_index_bits);
        mask = (64'd1 << n) - 64'd1;
        slot = 32'(r.key & mask);
        case (r.action)
            ACT_PROBE:
            begin
                if (tt_slots.exists(slot) && tt_slots[slot].key == r.key)
                begin
                    ent = tt_slots[slot];
                    res.hit = 1'b1;
                    res.move_out = ent.move;
                    res.bound_kind = ent.bound;
                    sv = mate_shift($signed(ent.score), int'(r.ply), -1);
                    res.score_out = sv[15:0];
                    if (ent.depth >= r.depth_in)
                    begin
                        if (ent.bound == BOUND_EXACT)
                        begin
                            res.cutoff = 1'b1;
                        end
                        else
                        begin
                            if (ent.bound == BOUND_LOWER)
                            begin
                                if (sv > a)
                                begin
                                    a = sv;
                                end
                            end
                            else if (sv < b)
                            begin
                                b = sv;
                            end
                            res.cutoff = (a >= b);
                        end
                    end
                end
            end
            ACT_STORE:
            begin
                s = $signed(r.score_in);
                if (s <= a)
                begin
                    bnd = BOUND_UPPER;
                end
                else if (s >= b)
                begin
                    bnd = BOUND_LOWER;
                end
                else
                begin
                    bnd = BOUND_EXACT;
                end
                sv = mate_shift(clamp_score(s), int'(r.ply), 1);
                ent.valid = 1'b1;
                ent.key = r.key;
                ent.move = r.move_code;
                ent.score = sv[15:0];
                ent.depth = r.depth_in;
                ent.bound = bnd;
                tt_slots[slot] = ent;
                res.score_out = sv[15:0];
                res.bound_kind = bnd;
            end
            ACT_CLEAR:
            begin
                tt_slots.delete();
            end
            default:
            begin
            end
        endcase
        res.alpha_out = a[15:0];
        res.beta_out = b[15:0];
        return res;
    endfunction

    function automatic sts_req_t build_req(logic [1:0] act, logic [63:0] k, int mv, int score,
                                           int depth, int alpha, int beta, int ply_dist);
        sts_req_t r;
        r.action = act;
        r.key = k;
        r.move_code = 16'(mv);
        r.score_in = 16'(score);
        r.depth_in = 8'(depth);
        r.alpha_in = 16'(alpha);
        r.beta_in = 16'(beta);
        r.ply = 8'(ply_dist);
        return r;
    endfunction

    function automatic int random_score();
        int t;
        t = int'(model_mate_value) - PLY_LIMIT;
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, 400)) - 200;
            1: return clamp_score(t + int'($urandom_range(0, 260)) - 130);
            2: return clamp_score(-t - int'($urandom_range(0, 260)) + 130);
            3: return $signed(16'($urandom));
            4:
            begin
                case ($urandom_range(0, 2))
                    0: return 32767;
                    1: return -32767;
                    default: return -32768;
                endcase
            end
            default: return ($urandom_range(0, 1) != 0) ? t : -t;
        endcase
    endfunction

    function automatic sts_req_t random_item();
        sts_req_t r;
        int sel;
        int s;
        int alpha;
        int beta;
        sel = $urandom_range(0, 99);
        r.action = (sel < 50) ? ACT_PROBE : (sel < 95) ? ACT_STORE : ACT_UNUSED;
        r.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(0, 15)];
        r.move_code = 16'($urandom);
        r.depth_in = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
        r.ply = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 128));
        s = random_score();
        r.score_in = 16'(s);
        case ($urandom_range(0, 3))
            0:
            begin
                alpha = clamp_score(s - int'($urandom_range(1, 300)));
                beta = clamp_score(s + int'($urandom_range(1, 300)));
            end
            1:
            begin
                alpha = s;
                beta = clamp_score(s + int'($urandom_range(0, 300)));
            end
            2:
            begin
                alpha = $signed(16'($urandom));
                beta = $signed(16'($urandom));
            end
            default:
            begin
                alpha = random_score();
                beta = clamp_score(alpha + int'($urandom_range(1, 400)));
            end
        endcase
        r.alpha_in = 16'(alpha);
        r.beta_in = 16'(beta);
        return r;
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        sts_rsp_t want;
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_INDEX_BITS_USED: model_index_bits = cfg_data[4:0];
                    CFG_MATE_VALUE: model_mate_value = cfg_data[14:0];
                    default: ;
                endcase
            end
            if (req_valid && !req_stall)
            begin
                moved = 1'b1;
                req_taken = 1'b1;
                want = predict_tt_result(req);
                expected_rsps.push_back(want);
                if (req.action == ACT_PROBE)
                begin
                    probe_count++;
                    hit_count += want.hit;
                    cutoff_count += want.cutoff;
                end
                else if (req.action == ACT_STORE)
                begin
                    store_count++;
                end
                else if (req.action == ACT_CLEAR)
                begin
                    clear_count++;
                end
            end
            if (rsp_valid && !rsp_stall)
            begin
                moved = 1'b1;
                if (expected_rsps.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing pending, actual %0h", $time, rsp);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("hit", want.hit, rsp.hit);
                    check_field("cutoff", want.cutoff, rsp.cutoff);
                    check_field("move_out", want.move_out, rsp.move_out);
                    check_field("score_out", want.score_out, rsp.score_out);
                    check_field("alpha_out", want.alpha_out, rsp.alpha_out);
                    check_field("beta_out", want.beta_out, rsp.beta_out);
                    check_field("bound_kind", want.bound_kind, rsp.bound_kind);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_taken))
        begin
            req_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 12);
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            2: rsp_stall <= ((stall_tick % 11) < 5);
            default: rsp_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic queue_directed_items();
        pending_reqs.push_back(build_req(ACT_PROBE, 64'd0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, '1, 0, 0, 255, -32768, 32767, 255));
        pending_reqs.push_back(build_req(ACT_UNUSED, 64'd0, 16'hFFFF, 5, 3, -10, 10, 1));
        pending_reqs.push_back(build_req(ACT_STORE, 64'd0, 16'hFFFF, 100, 5, -50, 200, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, 64'd0, 0, 0, 5, -50, 200, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, 64'd0, 0, 0, 6, -50, 200, 0));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_A, 16'h0001, 300, 10, 300, 400, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_A, 0, 0, 3, -100, 500, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_A, 0, 0, 10, 400, 500, 0));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_B, 16'h8000, 500, 4, 0, 500, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_B, 0, 0, 4, 0, 400, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_B, 0, 0, 0, 600, 700, 0));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_C, 16'h1234, 31990, 8, -32767, 32767, 10));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_C, 0, 0, 8, -32767, 32767, 20));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_D, 7, -31990, 8, -32767, 32767, 10));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_D, 0, 0, 8, -32767, 32767, 3));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_E, 16'hFFFF, 32767, 255, -32768, 32767,
                                         128));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_E, 0, 0, 255, 32767, 32767, 0));
        pending_reqs.push_back(build_req(ACT_STORE, KEY_F, 16'h5555, -32768, 1, -32768, 0, 255));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_F, 0, 0, 1, -32768, 32767, 255));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_A ^ (64'd1 << 63), 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(build_req(ACT_STORE, '1, 16'hAAAA, 31872, 2, 31872, 31872, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, '1, 0, 0, 0, -1, 1, 128));
        pending_reqs.push_back(build_req(ACT_CLEAR, KEY_A, 16'hFFFF, -1, 255, -1, -1, 255));
        pending_reqs.push_back(build_req(ACT_PROBE, KEY_A, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(build_req(ACT_PROBE, 64'd0, 0, 0, 0, 0, 0, 0));
    endtask

    initial
    begin
        int unsigned phase_bits[PHASE_COUNT];
        int unsigned phase_mate[PHASE_COUNT];
        sts_req_t item;
        sts_req_t follow;
        int count;
        phase_bits = '{16, 0, 3, 31, 8, 1, 16};
        phase_mate = '{32000, 32767, 129, 20000, 100, 1000, 32000};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p > 0)
            begin
                wait_for_drain();
            end
            write_cfg(CFG_INDEX_BITS_USED, phase_bits[p]);
            write_cfg(CFG_MATE_VALUE, phase_mate[p]);
            @(posedge clk);
            for (int i = 0; i < 16; i++)
            begin
                key_pool[i] = (i < 8) ? {$urandom, $urandom}
                                      : key_pool[i - 8] ^ (64'd1 << $urandom_range(16, 63));
            end
            key_pool[0] = 64'd0;
            if (p == 0)
            begin
                queue_directed_items();
            end
            count = 0;
            while (count < PHASE_ITEMS)
            begin
                if ((p == 2 || p == 5) && count == PHASE_ITEMS / 2)
                begin
                    item = random_item();
                    item.action = ACT_CLEAR;
                    pending_reqs.push_back(item);
                    count++;
                end
                item = random_item();
                pending_reqs.push_back(item);
                count++;
                if (item.action == ACT_STORE && $urandom_range(0, 1) != 0)
                begin
                    follow = random_item();
                    follow.action = ACT_PROBE;
                    follow.key = item.key;
                    pending_reqs.push_back(follow);
                    count++;
                end
            end
        end
        wait_for_drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d probes (%0d hits, %0d cutoffs), %0d stores and %0d clears.",
                 probe_count, hit_count, cutoff_count, store_count, clear_count);
        $display("Index widths from 0 to 31 and mate values from 100 to 32767 were exercised.");
        if (mismatch_count == 0 && expected_rsps.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
